@@ rtl/frame_rate_drop_duplicate_top_macros.svh @@
// Assertion macros for the frame rate drop/duplicate block.
// Used by the top level; expects signals clk and rst in scope.
`ifndef FRAME_RATE_DROP_DUPLICATE_TOP_MACROS_SVH
`define FRAME_RATE_DROP_DUPLICATE_TOP_MACROS_SVH

// Checked property, quiet while reset is high
`define FRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds across reset
`define FRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/frd_pkg.sv @@
// Shared types, constants and helper functions for the frame rate
// drop/duplicate block. No dependencies.
package frd_pkg;

  localparam int MAX_RUN_DEF     = 64;
  localparam int PAD_LIMIT_DEF   = 25;
  localparam int HANDLE_BITS_DEF = 16;
  // Result counters: wide enough for the largest run or pad of any legal setting
  localparam int CNT_BITS        = 7;
  localparam int QUEUE_DEPTH     = 2;
  localparam logic [63:0] NS_PER_S = 64'd1000000000;

  localparam logic [1:0] CFG_OUT_NUM   = 2'd0;
  localparam logic [1:0] CFG_OUT_DEN   = 2'd1;
  localparam logic [1:0] CFG_IN_DEN    = 2'd2;
  localparam logic [1:0] CFG_START_1ST = 2'd3;

  typedef enum logic [1:0] {
    CMD_FRAME, CMD_SEGMENT, CMD_EOS, CMD_FLUSH
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK, ST_LATE, ST_NONEG, ST_NOTS, ST_CAPPED, ST_EOS_EMPTY
  } status_t;

  typedef enum logic [1:0] {
    MD_IDLE, MD_MUL, MD_DIV, MD_DONE
  } md_state_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_FR_SETUP, S_SO_WAIT, S_FR_DIFF, S_FR_CMP, S_FR_AFTER,
    S_FR_END, S_SEG_CHK, S_SEG_CLOSE, S_SEG_SET, S_PUSH, S_PUSH_WAIT,
    S_PUSH_CALC, S_PUSH_WR, S_DRAIN_RD, S_DRAIN_OUT
  } core_state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [62:0] time_value;
    logic        time_present;
    logic [62:0] frame_duration;
    logic        duration_present;
    logic [15:0] handle;
    logic [62:0] stop_time;
    logic        stop_present;
    logic [62:0] accumulated_time;
    logic        is_update;
  } item_t;

  typedef struct packed {
    logic [30:0] out_num;
    logic [30:0] out_den;
    logic [30:0] in_den;
    logic        start_at_first;
  } cfg_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [63:0] tstamp;
    logic [63:0] dur;
    logic [62:0] seq;
    logic        disc;
  } res_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] n_res;
    logic [CNT_BITS-1:0] rd_idx;
  } dbg_t;

  function automatic logic [63:0] absdiff(logic [63:0] a, logic [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Saturating 32-bit counter add
  function automatic logic [31:0] sat_add(logic [31:0] c, logic [CNT_BITS-1:0] v);
    logic [32:0] s;
    s = {1'b0, c} + 33'(v);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ rtl/frd_muldiv.sv @@
// Iterative floor(a*b/c) with saturation to all ones; 128-bit product.
// Depends on frd_pkg. Shift-add multiply, then restoring divide.
module frd_muldiv import frd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] c,
  output logic        done,
  output logic [63:0] q
);

  md_state_t    state, state_next;
  logic [127:0] ma;
  logic [63:0]  mb;
  logic [127:0] prod;
  logic [63:0]  cc;
  logic [5:0]   cnt;
  logic [63:0]  sh;
  logic         take;
  logic         ovf;

  // Divide step: shift in next dividend bit, subtract when it fits
  assign sh   = {prod[126:64], prod[63]};
  assign take = prod[127] || (sh >= cc);
  assign ovf  = (cc == 64'd0) || (prod[127:64] >= cc);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      MD_IDLE: if (start) state_next = MD_MUL;
      MD_MUL: begin
        if (cnt == 6'd63) state_next = MD_DIV;
      end
      MD_DIV: begin
        if (ovf && cnt == 6'd0) state_next = MD_DONE;
        else if (cnt == 6'd63) state_next = MD_DONE;
      end
      MD_DONE: state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done = (state == MD_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= MD_IDLE;
    else     state <= state_next;
  end

  // Datapath; the first divide cycle also checks for overflow
  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        if (start) begin
          ma   <= {64'd0, a};
          mb   <= b;
          cc   <= c;
          prod <= '0;
          cnt  <= '0;
        end
      end
      MD_MUL: begin
        if (mb[0]) prod <= prod + ma;
        ma  <= ma << 1;
        mb  <= mb >> 1;
        cnt <= cnt + 6'd1;
        q   <= '0;
      end
      MD_DIV: begin
        if (ovf && cnt == 6'd0) begin
          q <= '1;
        end else begin
          prod[63:0] <= {prod[62:0], 1'b0};
          prod[127:64] <= take ? sh - cc : sh;
          q   <= {q[62:0], take};
          cnt <= cnt + 6'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/frd_front.sv @@
// Front end: input request queue, command decode and handle masking.
// Depends on frd_pkg.
module frd_front import frd_pkg::*; #(
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [62:0] time_value,
  input  logic        time_present,
  input  logic [62:0] frame_duration,
  input  logic        duration_present,
  input  logic [15:0] frame_handle,
  input  logic [62:0] stop_time,
  input  logic        stop_present,
  input  logic [62:0] accumulated_time,
  input  logic        is_update,
  output item_t       item,
  output logic        item_valid,
  input  logic        item_pop
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [15:0] HMASK =
    (HANDLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << HANDLE_BITS) - 32'd1);

  item_t             q_mem [QUEUE_DEPTH];
  logic [QW-1:0]     wptr, rptr;
  logic [QW:0]       count;
  item_t             in_item;
  logic              push, pop;

  // Classify the incoming request
  always_comb begin
    in_item.cmd              = cmd_t'(command);
    in_item.time_value       = time_value;
    in_item.time_present     = time_present;
    in_item.frame_duration   = frame_duration;
    in_item.duration_present = duration_present;
    in_item.handle           = frame_handle & HMASK;
    in_item.stop_time        = stop_time;
    in_item.stop_present     = stop_present;
    in_item.accumulated_time = accumulated_time;
    in_item.is_update        = is_update;
  end

  assign in_ready   = (count != (QW+1)'(QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign item_valid = (count != '0);
  assign pop        = item_pop && item_valid;
  assign item       = q_mem[rptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem[wptr] <= in_item;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == QW'(QUEUE_DEPTH-1)) ? '0 : wptr + QW'(1);
      if (pop)  rptr <= (rptr == QW'(QUEUE_DEPTH-1)) ? '0 : rptr + QW'(1);
      count <= count + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

endmodule

@@ rtl/frd_core.sv @@
// Back end: sequencer that runs frame, segment, end-of-stream and flush
// requests, buffers the pushes and drains them. Depends on frd_pkg.
module frd_core import frd_pkg::*; #(
  parameter int MAX_RUN   = MAX_RUN_DEF,
  parameter int PAD_LIMIT = PAD_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  item_t       item,
  input  logic        item_valid,
  output logic        item_pop,
  output logic        md_start,
  output logic [63:0] md_a,
  output logic [63:0] md_b,
  output logic [63:0] md_c,
  input  logic        md_done,
  input  logic [63:0] md_q,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        emit,
  output logic [15:0] out_handle,
  output logic [63:0] out_time,
  output logic [63:0] out_duration,
  output logic [62:0] out_sequence,
  output logic        discontinuity,
  output logic [2:0]  status,
  output logic [31:0] drop_total,
  output logic [31:0] dup_total,
  output logic        last,
  output dbg_t        dbg
);

  localparam int RES_DEPTH = (MAX_RUN > PAD_LIMIT + 1) ? MAX_RUN : PAD_LIMIT + 1;
  localparam int AW = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;

  core_state_t state, state_next, ret_st;
  item_t       cur;

  // Block state
  logic [15:0] held_handle;
  logic        held_valid;
  logic [63:0] held_time, next_out_time, expected_time;
  logic        next_out_valid, expected_valid, first_pending, seg_stop_valid;
  logic [63:0] total_out, segment_outputs, seg_start, seg_accum, seg_stop;
  logic [31:0] drops, dups;

  // Work registers
  logic [63:0]         in_ts, intime, d1, d2, p_due, p_dur, p_base;
  logic [62:0]         p_seq;
  logic                p_disc;
  logic [CNT_BITS-1:0] count, n_res, rd_idx;
  status_t             status_r;
  res_t                res_mem [RES_DEPTH];
  res_t                rdata;

  // Decode helpers
  logic        no_rate, no_ts, setup_so, late, seg_close, pad_more;
  logic [63:0] ts_sel, intime_w, den_ns, so_a;

  assign no_rate  = (cfg.in_den == '0) || (cfg.out_den == '0);
  assign no_ts    = !cur.time_present && !expected_valid;
  assign ts_sel   = cur.time_present ? {1'b0, cur.time_value} : expected_time;
  assign intime_w = in_ts + seg_accum;
  assign late     = held_valid && (intime_w < held_time);
  assign setup_so = !held_valid && !next_out_valid && cfg.start_at_first;
  assign den_ns   = 64'(cfg.out_den) * NS_PER_S;
  assign so_a     = (in_ts > seg_start) ? in_ts - seg_start : 64'd0;
  assign seg_close = !cur.is_update && held_valid;
  assign pad_more = (count <= CNT_BITS'(PAD_LIMIT)) &&
                    ((seg_stop_valid && (next_out_time - seg_accum < seg_stop)) ||
                     (count == '0));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (item_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (cur.cmd)
          CMD_FRAME:   state_next = (no_rate || no_ts) ? S_DRAIN_RD : S_FR_SETUP;
          CMD_SEGMENT: state_next = seg_close ? S_SEG_CHK : S_SEG_SET;
          CMD_EOS:     state_next = held_valid ? S_PUSH : S_DRAIN_RD;
          default:     state_next = S_DRAIN_RD;
        endcase
      end
      S_FR_SETUP: begin
        if (!held_valid)  state_next = setup_so ? S_SO_WAIT : S_DRAIN_RD;
        else if (late)    state_next = S_DRAIN_RD;
        else              state_next = S_FR_DIFF;
      end
      S_SO_WAIT:   if (md_done) state_next = S_DRAIN_RD;
      S_FR_DIFF:   state_next = S_FR_CMP;
      S_FR_CMP:    state_next = (d1 <= d2) ? S_PUSH : S_FR_AFTER;
      S_FR_AFTER: begin
        state_next = (d1 < d2 && count < CNT_BITS'(MAX_RUN)) ? S_FR_DIFF : S_FR_END;
      end
      S_FR_END:    state_next = S_DRAIN_RD;
      S_SEG_CHK:   state_next = pad_more ? S_PUSH : S_SEG_CLOSE;
      S_SEG_CLOSE: state_next = S_SEG_SET;
      S_SEG_SET:   state_next = S_DRAIN_RD;
      S_PUSH:      state_next = (cfg.out_num != '0) ? S_PUSH_WAIT : S_PUSH_WR;
      S_PUSH_WAIT: if (md_done) state_next = S_PUSH_CALC;
      S_PUSH_CALC: state_next = S_PUSH_WR;
      S_PUSH_WR:   state_next = ret_st;
      S_DRAIN_RD:  state_next = S_DRAIN_OUT;
      S_DRAIN_OUT: if (out_ready) state_next = last ? S_IDLE : S_DRAIN_RD;
      default:     state_next = S_IDLE;
    endcase
  end

  // Control outputs and divider operands
  always_comb begin
    item_pop  = (state == S_IDLE) && item_valid;
    out_valid = (state == S_DRAIN_OUT);
    md_start  = ((state == S_FR_SETUP) && setup_so) ||
                ((state == S_PUSH) && (cfg.out_num != '0));
    if (state == S_FR_SETUP) begin
      md_a = so_a;
      md_b = 64'(cfg.out_num);
      md_c = den_ns;
    end else begin
      md_a = segment_outputs + 64'd1;
      md_b = den_ns;
      md_c = 64'(cfg.out_num);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Block state and work registers
  always_ff @(posedge clk) begin
    if (rst || (state == S_DISPATCH && cur.cmd == CMD_FLUSH)) begin
      held_handle <= '0;  held_valid <= 1'b0;  held_time <= '0;
      next_out_time <= '0;  next_out_valid <= 1'b0;
      expected_time <= '0;  expected_valid <= 1'b0;
      total_out <= '0;  segment_outputs <= '0;  first_pending <= 1'b1;
      seg_start <= '0;  seg_accum <= '0;  seg_stop <= '0;  seg_stop_valid <= 1'b0;
      drops <= '0;  dups <= '0;
      status_r <= ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur      <= item;
            n_res    <= '0;
            count    <= '0;
            status_r <= ST_OK;
          end
        end
        S_DISPATCH: begin
          case (cur.cmd)
            CMD_FRAME: begin
              if (no_rate) begin
                status_r <= ST_NONEG;
              end else if (no_ts) begin
                status_r <= ST_NOTS;
              end else begin
                in_ts <= ts_sel;
                expected_time <= ts_sel +
                  (cur.duration_present ? {1'b0, cur.frame_duration} : 64'd0);
                expected_valid <= 1'b1;
              end
            end
            CMD_EOS: begin
              if (held_valid) ret_st <= S_DRAIN_RD;
              else            status_r <= ST_EOS_EMPTY;
            end
            default: ;
          endcase
        end
        S_FR_SETUP: begin
          intime <= intime_w;
          if (!held_valid) begin
            held_valid  <= 1'b1;
            held_handle <= cur.handle;
            held_time   <= intime_w;
            if (!next_out_valid) begin
              next_out_valid <= 1'b1;
              next_out_time  <= cfg.start_at_first ? intime_w : seg_start + seg_accum;
            end
          end else if (late) begin
            drops    <= sat_add(drops, CNT_BITS'(1));
            status_r <= ST_LATE;
          end
        end
        S_SO_WAIT: if (md_done) segment_outputs <= md_q;
        S_FR_DIFF: begin
          d1 <= absdiff(held_time, next_out_time);
          d2 <= absdiff(intime, next_out_time);
        end
        S_FR_CMP: ret_st <= S_FR_AFTER;
        S_FR_END: begin
          if (count > CNT_BITS'(1))   dups  <= sat_add(dups, count - CNT_BITS'(1));
          else if (count == '0)       drops <= sat_add(drops, CNT_BITS'(1));
          held_handle <= cur.handle;
          held_time   <= intime;
          status_r    <= (d1 < d2) ? ST_CAPPED : ST_OK;
        end
        S_SEG_CHK: ret_st <= S_SEG_CHK;
        S_SEG_CLOSE: begin
          if (count > CNT_BITS'(1)) dups <= sat_add(dups, count - CNT_BITS'(1));
          segment_outputs <= '0;
          held_valid      <= 1'b0;
          held_time       <= '0;
          next_out_valid  <= 1'b0;
        end
        S_SEG_SET: begin
          seg_start      <= {1'b0, cur.time_value};
          seg_stop       <= {1'b0, cur.stop_time};
          seg_stop_valid <= cur.stop_present;
          seg_accum      <= {1'b0, cur.accumulated_time};
        end
        // One push of the held frame
        S_PUSH: begin
          p_due  <= next_out_time;
          p_seq  <= total_out[62:0];
          p_disc <= first_pending;
          p_base <= seg_accum + seg_start;
          p_dur  <= '0;
          first_pending   <= 1'b0;
          total_out       <= total_out + 64'd1;
          segment_outputs <= segment_outputs + 64'd1;
          count           <= count + CNT_BITS'(1);
        end
        S_PUSH_WAIT: if (md_done) next_out_time <= p_base + md_q;
        S_PUSH_CALC: p_dur <= next_out_time - p_due;
        S_PUSH_WR:   n_res <= n_res + CNT_BITS'(1);
        S_DRAIN_OUT: if (out_ready) rd_idx <= rd_idx + CNT_BITS'(1);
        default: ;
      endcase
      if (state == S_IDLE) rd_idx <= '0;
    end
  end

  // Result buffer
  always_ff @(posedge clk) begin
    if (state == S_PUSH_WR) begin
      res_mem[n_res[AW-1:0]] <= '{handle: held_handle, tstamp: p_due - seg_accum,
                                  dur: p_dur, seq: p_seq, disc: p_disc};
    end
    if (state == S_DRAIN_RD) rdata <= res_mem[rd_idx[AW-1:0]];
  end

  // Result fields; an input with no push gives one empty result
  assign emit          = (n_res != '0);
  assign out_handle    = emit ? rdata.handle : '0;
  assign out_time      = emit ? rdata.tstamp : '0;
  assign out_duration  = emit ? rdata.dur    : '0;
  assign out_sequence  = emit ? rdata.seq    : '0;
  assign discontinuity = emit && rdata.disc;
  assign status        = status_r;
  assign drop_total    = drops;
  assign dup_total     = dups;
  assign last          = !emit || (rd_idx == n_res - CNT_BITS'(1));
  assign dbg.n_res     = n_res;
  assign dbg.rd_idx    = rd_idx;

endmodule

@@ rtl/frame_rate_drop_duplicate_top.sv @@
// Top level of the frame rate drop/duplicate converter.
// Depends on frd_pkg, frd_front, frd_core, frd_muldiv and the macros header.
//
//  channel | signals                          | accepted when
//  --------+----------------------------------+----------------------------
//  input   | in_valid/in_ready + item fields  | in_valid & in_ready
//  output  | out_valid/out_ready + results    | out_valid & out_ready
//  config  | cfg_we, cfg_index, cfg_data      | cfg_we
//
// Each push of the held frame runs the shared multiply/divide unit when the output
// rate is nonzero (start, multiply steps, divide steps, done, two write-back states);
// the divide stops at its first step when it saturates. The first frame with start
// at first runs the unit once more. Draining reads each result, then offers it and
// holds while out_ready is low. Reset clears the state machines, queue pointers,
// configuration and block state at once; no clearing pass. A two-entry queue
// takes requests while the back end works or waits on out_ready.
`include "frame_rate_drop_duplicate_top_macros.svh"
module frame_rate_drop_duplicate_top import frd_pkg::*; #(
  parameter int MAX_RUN     = MAX_RUN_DEF,
  parameter int PAD_LIMIT   = PAD_LIMIT_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [62:0]        time_value,
  input  logic               time_present,
  input  logic [62:0]        frame_duration,
  input  logic               duration_present,
  input  logic [15:0]        frame_handle,
  input  logic [62:0]        stop_time,
  input  logic               stop_present,
  input  logic [62:0]        accumulated_time,
  input  logic               is_update,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               emit,
  output logic [15:0]        out_handle,
  output logic signed [63:0] out_time,
  output logic signed [63:0] out_duration,
  output logic [62:0]        out_sequence,
  output logic               discontinuity,
  output logic [2:0]         status,
  output logic [31:0]        drop_total,
  output logic [31:0]        dup_total,
  output logic               last
);

  cfg_t        cfg;
  item_t       item;
  logic        item_valid, item_pop;
  logic        md_start, md_done;
  logic [63:0] md_a, md_b, md_c, md_q;
  logic [63:0] time_u, dur_u;
  dbg_t        dbg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUT_NUM:   cfg.out_num        <= cfg_data;
        CFG_OUT_DEN:   cfg.out_den        <= cfg_data;
        CFG_IN_DEN:    cfg.in_den         <= cfg_data;
        CFG_START_1ST: cfg.start_at_first <= cfg_data[0];
        default: ;
      endcase
    end
  end

  frd_front #(.HANDLE_BITS(HANDLE_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .command, .time_value, .time_present,
    .frame_duration, .duration_present, .frame_handle, .stop_time,
    .stop_present, .accumulated_time, .is_update,
    .item, .item_valid, .item_pop
  );

  frd_core #(.MAX_RUN(MAX_RUN), .PAD_LIMIT(PAD_LIMIT)) u_core (
    .clk, .rst, .cfg, .item, .item_valid, .item_pop,
    .md_start, .md_a, .md_b, .md_c, .md_done, .md_q,
    .out_valid, .out_ready, .emit, .out_handle,
    .out_time(time_u), .out_duration(dur_u), .out_sequence, .discontinuity,
    .status, .drop_total, .dup_total, .last, .dbg
  );

  frd_muldiv u_muldiv (
    .clk, .rst, .start(md_start), .a(md_a), .b(md_b), .c(md_c),
    .done(md_done), .q(md_q)
  );

  assign out_time     = $signed(time_u);
  assign out_duration = $signed(dur_u);

  // Checks
  `FRD_ASSERT(a_gap_after_last, out_valid && out_ready && last |=> !out_valid, "result after last")
  `FRD_ASSERT(a_idx_in_range, out_valid |-> (dbg.n_res == 0 || dbg.rd_idx < dbg.n_res), "bad index")
  `FRD_ASSERT_ALWAYS(a_quiet_after_reset, rst |=> !out_valid, "result right after reset")

endmodule
